/* src/money_string_parser_macros.svh */
// Assertion helpers shared by the parser blocks.
`ifndef MONEY_STRING_PARSER_MACROS_SVH
`define MONEY_STRING_PARSER_MACROS_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* src/msp_pkg.sv */
package msp_pkg;

  localparam int CHAR_W     = 8;
  localparam int AMOUNT_W   = 64;
  localparam int FRAC_W     = 4;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_CHAR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_DIGITS  = CFG_IDX_W'(1);

  typedef struct packed {
    logic              neg;
    logic              sat;
    logic [STEP_W-1:0] steps;
  } msp_ctl_t;

endpackage

/* src/msp_char_if.sv */
interface msp_char_if;
  import msp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              start_of_text;

  modport source (output valid, output char_code, output start_of_text, input ready);
  modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

/* src/msp_amount_if.sv */
interface msp_amount_if;
  import msp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [AMOUNT_W-1:0] amount;
  logic                       overflow;

  modport source (output valid, output amount, output overflow, input ready);
  modport sink   (input valid, input amount, input overflow, output ready);
endinterface

/* src/msp_parser.sv */
`include "money_string_parser_macros.svh"

module msp_parser #(
  parameter int MAX_PLACES = 9,
  parameter int MAG_W      = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [msp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0] wr_data,
  msp_char_if.sink                       chars,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [MAG_W-1:0]               out_mag,
  output msp_pkg::msp_ctl_t              out_ctl
);
  import msp_pkg::*;

  localparam int PW    = $clog2(MAX_PLACES + 1);
  localparam int ACC_W = MAG_W + 4;
  localparam logic [PW-1:0]    PLACES_MAX = PW'(MAX_PLACES);
  localparam logic [MAG_W-1:0] MAG_MAX    = '1;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_FIVE   = 8'h35;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_BODY,
    PH_DONE
  } phase_t;

  phase_t             phase;
  logic               is_negative;
  logic               point_seen;
  logic [MAG_W-1:0]   magnitude;
  logic [PW-1:0]      fraction_count;
  logic               saturated;
  logic [CHAR_W-1:0]  decimal_char;
  logic [FRAC_W-1:0]  frac_digits;

  phase_t             phase_next;
  logic               is_negative_next;
  logic               point_seen_next;
  logic [MAG_W-1:0]   magnitude_next;
  logic [PW-1:0]      fraction_count_next;
  logic               saturated_next;

  phase_t             cur_phase;
  logic               cur_neg;
  logic               cur_pt;
  logic [MAG_W-1:0]   cur_mag;
  logic [PW-1:0]      cur_fc;
  logic               cur_sat;

  logic               fire;
  logic               emit;
  logic               body;
  logic [CHAR_W-1:0]  c;
  logic [PW-1:0]      places;
  logic               is_digit;
  logic               is_space;
  logic               round_up;
  logic               round_ovf;
  logic [ACC_W-1:0]   acc;
  logic               acc_ovf;
  logic [MAG_W-1:0]   end_mag;
  logic               end_sat;

  assign chars.ready = !out_valid || out_ready;
  assign fire        = chars.valid && chars.ready;
  assign c           = chars.char_code;

  always_comb begin
    if (32'(frac_digits) > MAX_PLACES) begin
      places = PLACES_MAX;
    end else begin
      places = PW'(frac_digits);
    end
  end

  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign round_up  = is_digit && (c >= CH_FIVE);

  assign cur_phase = chars.start_of_text ? PH_LEAD : phase;
  assign cur_neg   = chars.start_of_text ? 1'b0 : is_negative;
  assign cur_pt    = chars.start_of_text ? 1'b0 : point_seen;
  assign cur_mag   = chars.start_of_text ? '0 : magnitude;
  assign cur_fc    = chars.start_of_text ? '0 : fraction_count;
  assign cur_sat   = chars.start_of_text ? 1'b0 : saturated;

  assign acc       = (ACC_W'(cur_mag) << 3) + (ACC_W'(cur_mag) << 1) + ACC_W'(c[3:0]);
  assign acc_ovf   = cur_sat || (acc[ACC_W-1:MAG_W] != '0);
  assign round_ovf = (cur_mag == MAG_MAX);
  assign end_sat   = cur_sat || (round_up && round_ovf);

  always_comb begin
    if (!round_up) begin
      end_mag = cur_mag;
    end else if (round_ovf) begin
      end_mag = MAG_MAX;
    end else begin
      end_mag = cur_mag + MAG_W'(1);
    end
  end

  always_comb begin
    phase_next          = cur_phase;
    is_negative_next    = cur_neg;
    point_seen_next     = cur_pt;
    magnitude_next      = cur_mag;
    fraction_count_next = cur_fc;
    saturated_next      = cur_sat;
    body                = 1'b0;
    emit                = 1'b0;
    unique case (cur_phase)
      PH_LEAD: begin
        if (!(is_space || (c == CH_DOLLAR))) begin
          phase_next = PH_BODY;
          if ((c == CH_MINUS) || (c == CH_LPAREN)) begin
            is_negative_next = 1'b1;
          end else if (c != CH_PLUS) begin
            body = 1'b1;
          end
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      default: begin
        body = 1'b0;
      end
    endcase
    if (body) begin
      if (is_digit && (!cur_pt || (cur_fc < places))) begin
        magnitude_next = acc_ovf ? MAG_MAX : acc[MAG_W-1:0];
        saturated_next = acc_ovf;
        if (cur_pt) begin
          fraction_count_next = cur_fc + PW'(1);
        end
      end else if ((c == decimal_char) && !cur_pt) begin
        point_seen_next = 1'b1;
      end else begin
        emit       = 1'b1;
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      is_negative    <= 1'b0;
      point_seen     <= 1'b0;
      magnitude      <= '0;
      fraction_count <= '0;
      saturated      <= 1'b0;
      decimal_char   <= 8'd46;
      frac_digits    <= 4'd2;
      out_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_index == CFG_DECIMAL_CHAR) begin
          decimal_char <= wr_data;
        end else if (wr_index == CFG_FRAC_DIGITS) begin
          frac_digits <= wr_data[FRAC_W-1:0];
        end
      end
      if (fire) begin
        phase          <= phase_next;
        is_negative    <= is_negative_next;
        point_seen     <= point_seen_next;
        magnitude      <= magnitude_next;
        fraction_count <= fraction_count_next;
        saturated      <= saturated_next;
      end
      if (chars.ready) begin
        out_valid <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_mag       <= end_mag;
      out_ctl.neg   <= cur_neg;
      out_ctl.sat   <= end_sat;
      out_ctl.steps <= (cur_fc < places) ? STEP_W'(places - cur_fc) : '0;
    end
  end

  `MSP_ASSERT_NOW(a_done_silent, clk, rst, fire && !chars.start_of_text && (phase == PH_DONE), !emit)
  `MSP_ASSERT_NEXT(a_emit_valid, clk, rst, fire && emit, out_valid)
endmodule

/* src/msp_pad_stage.sv */
`include "money_string_parser_macros.svh"

module msp_pad_stage #(
  parameter int MAG_W = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [MAG_W-1:0]  up_mag,
  input  msp_pkg::msp_ctl_t up_ctl,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [MAG_W-1:0]  dn_mag,
  output msp_pkg::msp_ctl_t dn_ctl
);
  import msp_pkg::*;

  localparam int ACC_W = MAG_W + 4;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  logic             active;
  logic [ACC_W-1:0] acc;
  logic             acc_ovf;
  logic [MAG_W-1:0] mag_next;
  msp_ctl_t         ctl_next;

  assign up_ready = !dn_valid || dn_ready;
  assign active   = (up_ctl.steps != '0);
  assign acc      = (ACC_W'(up_mag) << 3) + (ACC_W'(up_mag) << 1);
  assign acc_ovf  = up_ctl.sat || (acc[ACC_W-1:MAG_W] != '0);

  always_comb begin
    ctl_next = up_ctl;
    mag_next = up_mag;
    if (active) begin
      ctl_next.steps = up_ctl.steps - STEP_W'(1);
      ctl_next.sat   = acc_ovf;
      mag_next       = acc_ovf ? MAG_MAX : acc[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_mag <= mag_next;
      dn_ctl <= ctl_next;
    end
  end

  `MSP_ASSERT_NOW(a_sat_at_max, clk, rst, dn_valid && dn_ctl.sat, dn_mag == MAG_MAX)
  `MSP_ASSERT_NEXT(a_sign_kept, clk, rst, up_valid && up_ready, dn_valid && (dn_ctl.neg == $past(up_ctl.neg)))
endmodule

/* src/msp_sign_stage.sv */
module msp_sign_stage #(
  parameter int RESULT_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [RESULT_BITS-2:0] up_mag,
  input  msp_pkg::msp_ctl_t      up_ctl,
  msp_amount_if.source           amounts
);
  import msp_pkg::*;

  logic signed [RESULT_BITS-1:0] mag_s;
  logic signed [RESULT_BITS-1:0] val;

  assign up_ready = !amounts.valid || amounts.ready;
  assign mag_s    = $signed({1'b0, up_mag});
  assign val      = up_ctl.neg ? -mag_s : mag_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      amounts.valid <= 1'b0;
    end else if (up_ready) begin
      amounts.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      amounts.amount   <= AMOUNT_W'(val);
      amounts.overflow <= up_ctl.sat;
    end
  end
endmodule

/* src/money_string_parser.sv */
// Money string parser: takes one character per beat on chars and returns one signed amount,
// scaled by ten to the power of frac_digits, on amounts for each character that ends an
// amount. It accepts a character every clock cycle while amounts is not back-pressured; a
// result passes through the parser register and the chain of MAX_PLACES multiply-by-ten
// stages that pad missing decimal places, followed by the sign register.
// Backpressure on amounts stalls the chain and then chars. Register 0 holds the decimal
// point code (reset '.'), register 1 the number of places (reset 2, capped at MAX_PLACES);
// write them only while no amount is in flight.
module money_string_parser #(
  parameter int MAX_PLACES  = 9,
  parameter int RESULT_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [msp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0] wr_data,
  msp_char_if.sink                       chars,
  msp_amount_if.source                   amounts
);
  import msp_pkg::*;

  localparam int MAG_W = RESULT_BITS - 1;

  logic [MAX_PLACES:0] vld;
  logic [MAX_PLACES:0] rdy;
  logic [MAG_W-1:0]    mag [MAX_PLACES+1];
  msp_ctl_t            ctl [MAX_PLACES+1];

  msp_parser #(
    .MAX_PLACES (MAX_PLACES),
    .MAG_W      (MAG_W)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .chars     (chars),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_mag   (mag[0]),
    .out_ctl   (ctl[0])
  );

  for (genvar i = 0; i < MAX_PLACES; i++) begin : g_pad
    msp_pad_stage #(
      .MAG_W (MAG_W)
    ) u_pad (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_mag   (mag[i]),
      .up_ctl   (ctl[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_mag   (mag[i+1]),
      .dn_ctl   (ctl[i+1])
    );
  end

  msp_sign_stage #(
    .RESULT_BITS (RESULT_BITS)
  ) u_sign (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[MAX_PLACES]),
    .up_ready (rdy[MAX_PLACES]),
    .up_mag   (mag[MAX_PLACES]),
    .up_ctl   (ctl[MAX_PLACES]),
    .amounts  (amounts)
  );
endmodule

/* verif/money_string_parser_test.sv */
`timescale 1ns / 1ps

module money_string_parser_test;
  import msp_pkg::*;

  localparam int MAX_PLACES  = 9;
  localparam int RESULT_BITS = 64;
  localparam int LATENCY     = MAX_PLACES + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 95;

  localparam logic [63:0] MAG_MAX = (64'd1 << (RESULT_BITS - 1)) - 64'd1;

  localparam logic [CHAR_W-1:0] CH_SPACE  = " ";
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = "$";
  localparam logic [CHAR_W-1:0] CH_MINUS  = "-";
  localparam logic [CHAR_W-1:0] CH_LPAREN = "(";
  localparam logic [CHAR_W-1:0] CH_RPAREN = ")";
  localparam logic [CHAR_W-1:0] CH_PLUS   = "+";
  localparam logic [CHAR_W-1:0] CH_ZERO   = "0";
  localparam logic [CHAR_W-1:0] CH_FIVE   = "5";
  localparam logic [CHAR_W-1:0] CH_NINE   = "9";
  localparam logic [CHAR_W-1:0] CH_X      = "x";

  typedef enum logic [1:0] {
    SCAN_LEAD,
    SCAN_BODY,
    SCAN_DONE
  } scan_state_t;

  typedef struct {
    logic signed [AMOUNT_W-1:0] amount;
    logic                       overflow;
  } amount_beat_t;

  class amount_scoreboard;
    logic [CHAR_W-1:0] point_code;
    logic [FRAC_W-1:0] places_cfg;
    scan_state_t       state;
    logic              neg;
    logic              point_seen;
    logic              sat;
    logic [63:0]       mag;
    logic [FRAC_W-1:0] frac_cnt;
    amount_beat_t      expected_q[$];
    int                errors;

    function new();
      point_code = ".";
      places_cfg = 4'd2;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      state = SCAN_LEAD;
      neg = 1'b0;
      point_seen = 1'b0;
      sat = 1'b0;
      mag = 64'd0;
      frac_cnt = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DECIMAL_CHAR: point_code = data;
        CFG_FRAC_DIGITS:  places_cfg = data[FRAC_W-1:0];
        default: ;
      endcase
    endfunction

    function void scale_add(logic [63:0] d);
      if (sat || mag > (MAG_MAX - d) / 64'd10) begin
        mag = MAG_MAX;
        sat = 1'b1;
      end else begin
        mag = mag * 64'd10 + d;
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic sot);
      logic [FRAC_W-1:0] p;
      logic              dig;
      amount_beat_t      beat;
      p = (places_cfg > MAX_PLACES) ? FRAC_W'(MAX_PLACES) : places_cfg;
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      if (sot) clear_text();
      if (state == SCAN_LEAD) begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_DOLLAR) return;
        state = SCAN_BODY;
        if (c == CH_MINUS || c == CH_LPAREN) begin
          neg = 1'b1;
          return;
        end
        if (c == CH_PLUS) return;
      end
      if (state != SCAN_BODY) return;
      if (dig && (!point_seen || frac_cnt < p)) begin
        scale_add(64'(c - CH_ZERO));
        if (point_seen) frac_cnt++;
        return;
      end
      if (c == point_code && !point_seen) begin
        point_seen = 1'b1;
        return;
      end
      // round up on the first surplus digit
      if (dig && c >= CH_FIVE) begin
        if (mag >= MAG_MAX) begin
          mag = MAG_MAX;
          sat = 1'b1;
        end else begin
          mag++;
        end
      end
      while (frac_cnt < p) begin
        scale_add(64'd0);
        frac_cnt++;
      end
      state = SCAN_DONE;
      beat.amount = neg ? (64'd0 - mag) : mag;
      beat.overflow = sat;
      expected_q.push_back(beat);
    endfunction

    function void check_amount(logic signed [AMOUNT_W-1:0] amount, logic overflow);
      amount_beat_t beat;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected amount %0d overflow %0b", $time, amount, overflow);
        errors++;
        return;
      end
      beat = expected_q.pop_front();
      if (amount !== beat.amount) begin
        $display("%0t: amount mismatch: expected %0d, actual %0d",
                 $time, beat.amount, amount);
        errors++;
      end
      if (overflow !== beat.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, beat.overflow, overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic hold_start;
  int   hold_cnt = 0;
  int   src_idle = 0;
  int   snk_stall = 0;
  int   quiet_cycles = 0;

  amount_scoreboard sb = new();

  msp_char_if   chars();
  msp_amount_if amounts();

  money_string_parser #(
    .MAX_PLACES  (MAX_PLACES),
    .RESULT_BITS (RESULT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .chars    (chars),
    .amounts  (amounts)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (chars.valid && chars.ready) sb.note_char(chars.char_code, chars.start_of_text);
      if (amounts.valid && amounts.ready) sb.check_amount(amounts.amount, amounts.overflow);
    end
  end

  // long hold-off of the result side, counted here; random ready stalls otherwise
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      amounts.ready <= 1'b0;
    end else if (hold_start) begin
      hold_cnt <= HOLD_CYCLES;
      amounts.ready <= 1'b0;
    end else begin
      amounts.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    if ((chars.valid && chars.ready) || (amounts.valid && amounts.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic sot);
    while ($urandom_range(99) < src_idle) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.char_code <= code;
    chars.start_of_text <= sot;
    do @(posedge clk); while (!chars.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_results();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_amount(output int n);
    logic [CHAR_W-1:0] txt[$];
    int lead;
    int ndig;
    int nfrac;
    int trail;
    lead = $urandom_range(3);
    for (int i = 0; i < lead; i++) begin
      case ($urandom_range(2))
        0: txt.push_back(CH_SPACE);
        1: txt.push_back(CH_DOLLAR);
        default: txt.push_back(CHAR_W'($urandom_range(9, 13)));
      endcase
    end
    case ($urandom_range(4))
      0: txt.push_back(CH_MINUS);
      1: txt.push_back(CH_LPAREN);
      2: txt.push_back(CH_PLUS);
      default: ;
    endcase
    ndig = ($urandom_range(5) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 5);
    for (int i = 0; i < ndig; i++) txt.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
    if ($urandom_range(2) != 0) begin
      txt.push_back(sb.point_code);
      nfrac = $urandom_range(0, 11);
      for (int i = 0; i < nfrac; i++) txt.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
    end
    case ($urandom_range(3))
      0: txt.push_back(CH_SPACE);
      1: txt.push_back(CH_RPAREN);
      2: txt.push_back(CH_X);
      default: txt.push_back(CHAR_W'($urandom_range(255)));
    endcase
    trail = $urandom_range(2);
    for (int i = 0; i < trail; i++) txt.push_back(CHAR_W'($urandom_range(255)));
    n = txt.size();
    foreach (txt[i]) send_char(txt[i], i == 0);
  endtask

  task automatic send_noise(output int n);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  initial begin
    logic [CHAR_W-1:0] dec_tab[10];
    int frac_tab[10];
    int src_tab[4];
    int snk_tab[4];
    int cnt;
    int n;
    bit paused;
    dec_tab = '{".", ",", ".", "5", 8'h00, 8'hff, 8'h00, ".", "0", 8'h00};
    frac_tab = '{0, 9, 15, 2, 1, 9, 0, 4, 0, 0};
    src_tab = '{0, 74, 0, 28};
    snk_tab = '{0, 0, 74, 28};
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    hold_start <= 1'b0;
    chars.valid <= 1'b0;
    chars.char_code <= '0;
    chars.start_of_text <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_text("\t$(7.255;");
    send_text("+0.0 ");
    send_text("-0;");
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
    send_char("7", 1'b0);
    send_text("12.34 5");
    wait_results();
    repeat (LATENCY + 4) @(posedge clk);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 6 || ph == 9) begin
        dec_tab[ph] = CHAR_W'($urandom_range(255));
        frac_tab[ph] = $urandom_range(15);
      end
      write_reg(CFG_DECIMAL_CHAR, dec_tab[ph]);
      write_reg(CFG_FRAC_DIGITS, CFG_DATA_W'(frac_tab[ph]));
      src_idle = src_tab[ph % 4];
      snk_stall = snk_tab[ph % 4];
      if (ph == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      cnt = 0;
      paused = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) send_amount(n);
        else send_noise(n);
        cnt += n;
        if (ph == 2 && !paused && cnt >= PHASE_ITEMS / 2) begin
          paused = 1;
          wait_results();
        end
      end
      wait_results();
      repeat (LATENCY + 4) @(posedge clk);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* money_string_parser.f */
+incdir+src
src/msp_pkg.sv
src/msp_char_if.sv
src/msp_amount_if.sv
src/msp_parser.sv
src/msp_pad_stage.sv
src/msp_sign_stage.sv
src/money_string_parser.sv
verif/money_string_parser_test.sv
